// File: rtl/first_fit_exclusion_coloring_unit_assert.svh
// ----------------------------------------------------------------------------
// First-fit exclusion coloring unit: assertion macros
// Shorthand for the concurrent checks used in the RTL, clocked on clock and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_EXCLUSION_COLORING_UNIT_ASSERT_SVH
`define FIRST_FIT_EXCLUSION_COLORING_UNIT_ASSERT_SVH

// same-cycle implication
`define FFEC_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ffec check failed");

// next-cycle implication
`define FFEC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ffec check failed");

`endif

// File: rtl/ffec_pkg.sv
// ----------------------------------------------------------------------------
// ffec_pkg
// Shared types and codes of the first-fit exclusion coloring unit.
// ----------------------------------------------------------------------------
package ffec_pkg;

   // word field widths
   localparam int ACTION_W   = 2;
   localparam int VERTEX_W   = 8;
   localparam int ST_INDEX_W = 5;
   localparam int ST_TOTAL_W = 6;
   localparam int PR_TOTAL_W = 7;
   localparam int ERROR_W    = 2;

   // station search handles this many stations per cycle
   localparam int CHUNK      = 8;
   localparam int CHUNK_BITS = 3;

   localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_ASSIGN = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

   localparam logic [ERROR_W-1:0] ERR_OK         = 2'd0;
   localparam logic [ERROR_W-1:0] ERR_PAIRS_FULL = 2'd1;
   localparam logic [ERROR_W-1:0] ERR_NO_STATION = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_SEARCH,
      ST_DONE
   } state_type;

endpackage

// File: rtl/ffec_req_if.sv
// ----------------------------------------------------------------------------
// ffec_req_if
// Request channel: one word carries an action and two vertex ids.
// ----------------------------------------------------------------------------
interface ffec_req_if;
   logic                             valid;
   logic                             ready;
   logic [ffec_pkg::ACTION_W-1:0]    action;
   logic [ffec_pkg::VERTEX_W-1:0]    vertex_a;
   logic [ffec_pkg::VERTEX_W-1:0]    vertex_b;

   modport source (output valid, action, vertex_a, vertex_b, input ready);
   modport sink   (input valid, action, vertex_a, vertex_b, output ready);
endinterface

// File: rtl/ffec_rsp_if.sv
// ----------------------------------------------------------------------------
// ffec_rsp_if
// Response channel: one word per request with station and count results.
// ----------------------------------------------------------------------------
interface ffec_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [ffec_pkg::ST_INDEX_W-1:0]    station_index;
   logic [ffec_pkg::ST_TOTAL_W-1:0]    station_total;
   logic [ffec_pkg::PR_TOTAL_W-1:0]    pair_total;
   logic [ffec_pkg::ERROR_W-1:0]       error_code;

   modport source (output valid, station_index, station_total, pair_total, error_code,
                   input ready);
   modport sink   (input valid, station_index, station_total, pair_total, error_code,
                   output ready);
endinterface

// File: rtl/ffec_ram.sv
// ----------------------------------------------------------------------------
// ffec_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ffec_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/first_fit_exclusion_coloring_unit.sv
// ----------------------------------------------------------------------------
// first_fit_exclusion_coloring_unit
// Greedy first-fit placement of operation ids into stations under pairwise
// exclusion, with a pair store, a vertex-to-station table and a scan sequencer.
// ----------------------------------------------------------------------------
// Steps: load / unknown go straight to the response; assign scans the pair store,
//   one pair per cycle, then searches 8 stations per cycle; clear sweeps the
//   vertex table first.
// Throughput: one word at a time; the next request is taken the cycle after the
//   result enters the response register, which waits while rsp is stalled.
// Reset: synchronous; counts zeroed, then a vertex table sweep.

`include "first_fit_exclusion_coloring_unit_assert.svh"

module first_fit_exclusion_coloring_unit #(
   parameter int MAX_PAIRS    = 64,
   parameter int MAX_STATIONS = 32,
   parameter int ID_BITS      = 8
) (
   input  logic         clock,
   input  logic         reset,
   ffec_req_if.sink     req_chan,
   ffec_rsp_if.source   rsp_chan
);

   // ---------------------------------------------------------------- sizes
   localparam int IdW      = ID_BITS;
   localparam int IdDepth  = 1 << ID_BITS;
   localparam int PairAw   = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
   localparam int PcW      = $clog2(MAX_PAIRS + 1);
   localparam int SiW      = $clog2(MAX_STATIONS);
   localparam int ScW      = $clog2(MAX_STATIONS + 1);
   localparam int VsW      = SiW + 1;            // {valid, station}
   localparam int Chunks   = (MAX_STATIONS + ffec_pkg::CHUNK - 1) / ffec_pkg::CHUNK;
   localparam int MarkW    = Chunks * ffec_pkg::CHUNK;
   localparam int MarkAw   = $clog2(MarkW);
   localparam int ChW      = (Chunks > 1) ? $clog2(Chunks) : 1;
   localparam int SlotW    = ChW + ffec_pkg::CHUNK_BITS;
   localparam int CmpW     = (SlotW > ScW) ? SlotW : ScW;

   // ---------------------------------------------------------------- state
   ffec_pkg::state_type            state_ff, state_in;
   logic [PcW-1:0]                 pair_count_ff, pair_count_in;
   logic [ScW-1:0]                 station_count_ff, station_count_in;
   logic [IdW-1:0]                 id_ff, id_in;          // id being assigned
   logic [PcW-1:0]                 scan_ff, scan_in;      // next pair address
   logic                           s1_vld_ff, s1_vld_in;  // pair word returning
   logic                           s2_vld_ff, s2_vld_in;  // partner entry returning
   logic [MarkW-1:0]               mark_ff, mark_in;      // stations blocked
   logic [ChW-1:0]                 chunk_ff, chunk_in;
   logic [IdW-1:0]                 clr_addr_ff, clr_addr_in;
   logic                           clr_item_ff, clr_item_in; // sweep owes a word
   logic [SiW-1:0]                 res_idx_ff, res_idx_in;
   logic [ffec_pkg::ERROR_W-1:0]   res_err_ff, res_err_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [ffec_pkg::ST_INDEX_W-1:0]   rsp_idx_ff, rsp_idx_in;
   logic [ffec_pkg::ST_TOTAL_W-1:0]   rsp_stot_ff, rsp_stot_in;
   logic [ffec_pkg::PR_TOTAL_W-1:0]   rsp_ptot_ff, rsp_ptot_in;
   logic [ffec_pkg::ERROR_W-1:0]      rsp_err_ff, rsp_err_in;

   // ---------------------------------------------------------------- memories
   logic                 pair_wr_en;
   logic [PairAw-1:0]    pair_wr_addr;
   logic [2*IdW-1:0]     pair_wr_data;
   logic [PairAw-1:0]    pair_rd_addr;
   logic [2*IdW-1:0]     pair_rd_data;

   logic                 vtx_wr_en;
   logic [IdW-1:0]       vtx_wr_addr;
   logic [VsW-1:0]       vtx_wr_data;
   logic [IdW-1:0]       vtx_rd_addr;
   logic [VsW-1:0]       vtx_rd_data;

   // pair store: {second id, first id}; only entries below pair_count are read
   ffec_ram #(
      .WIDTH (2 * IdW),
      .DEPTH (MAX_PAIRS)
   ) u_pair_ram (
      .clock   (clock),
      .wr_en   (pair_wr_en),
      .wr_addr (pair_wr_addr),
      .wr_data (pair_wr_data),
      .rd_addr (pair_rd_addr),
      .rd_data (pair_rd_data)
   );

   // vertex table: {valid, station}, swept to zero after reset and on clear
   ffec_ram #(
      .WIDTH (VsW),
      .DEPTH (IdDepth)
   ) u_vtx_ram (
      .clock   (clock),
      .wr_en   (vtx_wr_en),
      .wr_addr (vtx_wr_addr),
      .wr_data (vtx_wr_data),
      .rd_addr (vtx_rd_addr),
      .rd_data (vtx_rd_data)
   );

   // ---------------------------------------------------------------- request ids
   logic [IdW-1:0] id_a;
   logic [IdW-1:0] id_b;

   assign id_a = IdW'(req_chan.vertex_a);
   assign id_b = IdW'(req_chan.vertex_b);

   // ---------------------------------------------------------------- scan pipe
   // stage 1: pair word back from the store, pick the partner of the id
   // stage 2: partner's table entry back, mark its station
   logic [IdW-1:0] pair_lo;
   logic [IdW-1:0] pair_hi;
   logic           hit_lo;
   logic           hit_hi;

   assign pair_lo      = pair_rd_data[IdW-1:0];
   assign pair_hi      = pair_rd_data[2*IdW-1:IdW];
   assign hit_lo       = (pair_lo == id_ff);
   assign hit_hi       = (pair_hi == id_ff);
   assign vtx_rd_addr  = hit_lo ? pair_hi : pair_lo;   // pair (a,a) gives a either way
   assign s2_vld_in    = s1_vld_ff && (hit_lo || hit_hi);
   assign pair_rd_addr = PairAw'(scan_ff);

   // ---------------------------------------------------------------- station search
   // eight stations per cycle: lowest one below station_count that is not marked
   logic [ffec_pkg::CHUNK-1:0]      free_vec;
   logic [ffec_pkg::CHUNK_BITS-1:0] pick_j;
   logic                            any_free;

   always_comb begin
      logic [SlotW-1:0] slot;
      free_vec = '0;
      pick_j   = '0;
      for (int j = 0; j < ffec_pkg::CHUNK; j++) begin
         slot        = {chunk_ff, ffec_pkg::CHUNK_BITS'(j)};
         free_vec[j] = !mark_ff[MarkAw'(slot)] && (CmpW'(slot) < CmpW'(station_count_ff));
      end
      for (int j = ffec_pkg::CHUNK - 1; j >= 0; j--) begin
         if (free_vec[j]) begin
            pick_j = ffec_pkg::CHUNK_BITS'(j);
         end
      end
      any_free = |free_vec;
   end

   // ---------------------------------------------------------------- sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ffec_pkg::ST_CLEAR;
         pair_count_ff    <= '0;
         station_count_ff <= '0;
         s1_vld_ff        <= 1'b0;
         s2_vld_ff        <= 1'b0;
         clr_addr_ff      <= '0;
         clr_item_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         pair_count_ff    <= pair_count_in;
         station_count_ff <= station_count_in;
         s1_vld_ff        <= s1_vld_in;
         s2_vld_ff        <= s2_vld_in;
         clr_addr_ff      <= clr_addr_in;
         clr_item_ff      <= clr_item_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff       <= id_in;
      scan_ff     <= scan_in;
      mark_ff     <= mark_in;
      chunk_ff    <= chunk_in;
      res_idx_ff  <= res_idx_in;
      res_err_ff  <= res_err_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_stot_ff <= rsp_stot_in;
      rsp_ptot_ff <= rsp_ptot_in;
      rsp_err_ff  <= rsp_err_in;
   end

   always_comb begin
      logic [SiW-1:0] new_idx;

      state_in         = state_ff;
      pair_count_in    = pair_count_ff;
      station_count_in = station_count_ff;
      id_in            = id_ff;
      scan_in          = scan_ff;
      s1_vld_in        = 1'b0;
      mark_in          = mark_ff;
      chunk_in         = chunk_ff;
      clr_addr_in      = clr_addr_ff;
      clr_item_in      = clr_item_ff;
      res_idx_in       = res_idx_ff;
      res_err_in       = res_err_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_chan.ready;
      rsp_idx_in       = rsp_idx_ff;
      rsp_stot_in      = rsp_stot_ff;
      rsp_ptot_in      = rsp_ptot_ff;
      rsp_err_in       = rsp_err_ff;
      req_chan.ready   = 1'b0;
      pair_wr_en       = 1'b0;
      pair_wr_addr     = PairAw'(pair_count_ff);
      pair_wr_data     = {id_b, id_a};
      vtx_wr_en        = 1'b0;
      vtx_wr_addr      = id_ff;
      vtx_wr_data      = '0;
      new_idx          = '0;

      // partner already placed: block its station
      if (s2_vld_ff && vtx_rd_data[SiW]) begin
         mark_in[MarkAw'(vtx_rd_data[SiW-1:0])] = 1'b1;
      end

      unique case (state_ff)
         ffec_pkg::ST_CLEAR: begin
            vtx_wr_en   = 1'b1;
            vtx_wr_addr = clr_addr_ff;
            vtx_wr_data = '0;
            clr_addr_in = clr_addr_ff + IdW'(1);
            if (clr_addr_ff == '1) begin
               clr_item_in = 1'b0;
               state_in    = clr_item_ff ? ffec_pkg::ST_DONE : ffec_pkg::ST_IDLE;
            end
         end

         ffec_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               res_idx_in = '0;
               res_err_in = ffec_pkg::ERR_OK;
               state_in   = ffec_pkg::ST_DONE;
               case (req_chan.action)
                  ffec_pkg::ACT_LOAD: begin
                     if (pair_count_ff < PcW'(MAX_PAIRS)) begin
                        pair_wr_en    = 1'b1;
                        pair_count_in = pair_count_ff + PcW'(1);
                     end else begin
                        res_err_in = ffec_pkg::ERR_PAIRS_FULL;
                     end
                  end
                  ffec_pkg::ACT_ASSIGN: begin
                     id_in    = id_a;
                     scan_in  = '0;
                     mark_in  = '0;
                     chunk_in = '0;
                     state_in = ffec_pkg::ST_SCAN;
                  end
                  ffec_pkg::ACT_CLEAR: begin
                     pair_count_in    = '0;
                     station_count_in = '0;
                     clr_addr_in      = '0;
                     clr_item_in      = 1'b1;
                     state_in         = ffec_pkg::ST_CLEAR;
                  end
                  default: begin
                     // unknown action: nothing changes
                  end
               endcase
            end
         end

         ffec_pkg::ST_SCAN: begin
            if (scan_ff != pair_count_ff) begin
               s1_vld_in = 1'b1;
               scan_in   = scan_ff + PcW'(1);
            end else if (!s1_vld_ff && !s2_vld_ff) begin
               state_in = ffec_pkg::ST_SEARCH;
            end
         end

         ffec_pkg::ST_SEARCH: begin
            if (any_free) begin
               new_idx     = SiW'({chunk_ff, pick_j});
               vtx_wr_en   = 1'b1;
               vtx_wr_data = {1'b1, new_idx};
               res_idx_in  = new_idx;
               res_err_in  = ffec_pkg::ERR_OK;
               state_in    = ffec_pkg::ST_DONE;
            end else if (chunk_ff == ChW'(Chunks - 1)) begin
               if (station_count_ff < ScW'(MAX_STATIONS)) begin
                  // every open station blocked: open a new one
                  new_idx          = SiW'(station_count_ff);
                  station_count_in = station_count_ff + ScW'(1);
                  vtx_wr_en        = 1'b1;
                  vtx_wr_data      = {1'b1, new_idx};
                  res_idx_in       = new_idx;
                  res_err_in       = ffec_pkg::ERR_OK;
               end else begin
                  res_idx_in = '0;
                  res_err_in = ffec_pkg::ERR_NO_STATION;
               end
               state_in = ffec_pkg::ST_DONE;
            end else begin
               chunk_in = chunk_ff + ChW'(1);
            end
         end

         ffec_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = ffec_pkg::ST_INDEX_W'(res_idx_ff);
               rsp_stot_in  = ffec_pkg::ST_TOTAL_W'(station_count_ff);
               rsp_ptot_in  = ffec_pkg::PR_TOTAL_W'(pair_count_ff);
               rsp_err_in   = res_err_ff;
               state_in     = ffec_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = ffec_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- response word
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.station_index = rsp_idx_ff;
   assign rsp_chan.station_total = rsp_stot_ff;
   assign rsp_chan.pair_total    = rsp_ptot_ff;
   assign rsp_chan.error_code    = rsp_err_ff;

   // ---------------------------------------------------------------- checks
   `FFEC_ASSERT_IMPL(a_station_bound, 1'b1, station_count_ff <= ScW'(MAX_STATIONS))
   `FFEC_ASSERT_IMPL(a_pair_bound, 1'b1, pair_count_ff <= PcW'(MAX_PAIRS))
   `FFEC_ASSERT_IMPL(a_pipe_in_scan, s1_vld_ff || s2_vld_ff, state_ff == ffec_pkg::ST_SCAN)
   `FFEC_ASSERT_IMPL(a_no_station_full,
      state_ff == ffec_pkg::ST_DONE && res_err_ff == ffec_pkg::ERR_NO_STATION,
      station_count_ff == ScW'(MAX_STATIONS))
   `FFEC_ASSERT_NEXT(a_scan_done_to_search,
      state_ff == ffec_pkg::ST_SCAN && scan_ff == pair_count_ff && !s1_vld_ff && !s2_vld_ff,
      state_ff == ffec_pkg::ST_SEARCH && chunk_ff == '0)

endmodule
